[src/kvc_pkg.sv]
// ---------------------------------------------------------------------------
// kvc_pkg: shared types and constants of the banked key/value FIFO cache
// Field widths, operation codes, parameter defaults, offload constants and the occupancy-width and byte-mask helpers.
// ---------------------------------------------------------------------------
package kvc_pkg;

   // parameter defaults
   localparam int LAYER_COUNT_DEF = 4;
   localparam int NUM_BANKS_DEF   = 4;
   localparam int BANK_DEPTH_DEF  = 16;
   localparam int WORD_BYTES_DEF  = 8;

   // transaction field widths
   localparam int FUNC_W  = 2;
   localparam int LAYER_W = 2;
   localparam int SEQ_W   = 12;
   localparam int DATA_W  = 64;
   localparam int LEN_W   = 4;
   localparam int EBANK_W = 2;
   localparam int EVC_W   = 32;
   localparam int PCT_W   = 7;

   // offload threshold: percent of bank depth
   localparam int PCT_RESET = 80;
   localparam int PCT_SCALE = 100;

   typedef enum logic [FUNC_W-1:0] {
      FUNC_STORE = 2'd0,
      FUNC_LOAD  = 2'd1,
      FUNC_EVICT = 2'd2,
      FUNC_QUERY = 2'd3
   } func_type;

   // width of an occupancy count that can hold the full depth
   function automatic int occ_width(input int depth);
      occ_width = $clog2(depth + 1);
   endfunction

   // low nbytes bytes set
   function automatic logic [DATA_W-1:0] byte_mask(input logic [LEN_W-1:0] nbytes);
      logic [DATA_W-1:0] m;
      m = '0;
      for (int i = 0; i < DATA_W / 8; i++) begin
         if (LEN_W'(i) < nbytes) begin
            m[8*i +: 8] = 8'hFF;
         end
      end
      byte_mask = m;
   endfunction

endpackage

[src/kvc_if.sv]
// ---------------------------------------------------------------------------
// kvc_if: valid/ready channels of the banked key/value FIFO cache
// Request, response and control-register write channels.
// ---------------------------------------------------------------------------
interface kvc_req_if;
   logic                         valid;
   logic                         ready;
   logic [kvc_pkg::FUNC_W-1:0]   func;
   logic [kvc_pkg::LAYER_W-1:0]  layer_index;
   logic [kvc_pkg::SEQ_W-1:0]    seq_pos;
   logic [kvc_pkg::DATA_W-1:0]   entry_data;
   logic [kvc_pkg::LEN_W-1:0]    entry_size;

   modport source (output valid, func, layer_index, seq_pos, entry_data, entry_size,
                   input ready);
   modport sink   (input valid, func, layer_index, seq_pos, entry_data, entry_size,
                   output ready);
endinterface

interface kvc_rsp_if;
   logic                         valid;
   logic                         ready;
   logic                         ok;
   logic [kvc_pkg::DATA_W-1:0]   read_data;
   logic [kvc_pkg::LEN_W-1:0]    bytes_copied;
   logic [kvc_pkg::EBANK_W-1:0]  evicted_bank;
   logic                         needs_offload;
   logic [kvc_pkg::EVC_W-1:0]    eviction_count;

   modport source (output valid, ok, read_data, bytes_copied, evicted_bank,
                   needs_offload, eviction_count, input ready);
   modport sink   (input valid, ok, read_data, bytes_copied, evicted_bank,
                   needs_offload, eviction_count, output ready);
endinterface

interface kvc_csr_if;
   logic                         valid;
   logic                         ready;
   logic [kvc_pkg::PCT_W-1:0]    offload_percent;

   modport source (output valid, offload_percent, input ready);
   modport sink   (input valid, offload_percent, output ready);
endinterface

[src/banked_kv_fifo_cache.sv]
// ---------------------------------------------------------------------------
// banked_kv_fifo_cache: banked ring-FIFO key/value cache
// Per-layer bank metadata and entry words live in two synchronous RAMs.
// ---------------------------------------------------------------------------
// Usage:
//   req_bus carries one operation per transaction (store, load, evict oldest,
//   query). rsp_bus returns exactly one result transaction per request, in
//   order. csr_bus writes the offload percentage; write it only while idle.
// Sequencing (one request in flight at a time):
//   a request passes the metadata RAM read, then the entry RAM read-modify-write
//   for store or the entry RAM read for load and evict; evict first scans the
//   layer's banks, one per cycle. A query or a refused store, load or evict
//   skips the entry RAM step, and a layer out of range skips all of them.
//   A result lands in the output register as the sequencer returns to idle,
//   so the next request is taken while that result waits to be taken.
// Reset:
//   synchronous; afterwards a clearing sweep zeroes both RAMs, one entry per
//   cycle, over all LAYER_COUNT*NUM_BANKS*BANK_DEPTH entry slots (256 at the defaults).
//   req_bus.ready stays low during the sweep; csr writes are taken as ever.
// Receiver stall:
//   the finished result holds in the output register; a following result
//   waits in the sequencer until the register drains.
// ---------------------------------------------------------------------------
module banked_kv_fifo_cache #(
   parameter int LAYER_COUNT = kvc_pkg::LAYER_COUNT_DEF,
   parameter int NUM_BANKS   = kvc_pkg::NUM_BANKS_DEF,
   parameter int BANK_DEPTH  = kvc_pkg::BANK_DEPTH_DEF,
   parameter int WORD_BYTES  = kvc_pkg::WORD_BYTES_DEF
) (
   input  logic      clock,
   input  logic      reset,
   kvc_req_if.sink   req_bus,
   kvc_rsp_if.source rsp_bus,
   kvc_csr_if.sink   csr_bus
);

   // widths
   localparam int TOTAL_SLOTS = LAYER_COUNT * NUM_BANKS * BANK_DEPTH;
   localparam int EAW  = $clog2(TOTAL_SLOTS > 1 ? TOTAL_SLOTS : 2);
   localparam int LAW  = $clog2(LAYER_COUNT > 1 ? LAYER_COUNT : 2);
   localparam int BW   = $clog2(NUM_BANKS > 1 ? NUM_BANKS : 2);
   localparam int PW   = $clog2(BANK_DEPTH > 1 ? BANK_DEPTH : 2);
   localparam int OW   = kvc_pkg::occ_width(BANK_DEPTH);
   localparam int EW   = 8 * WORD_BYTES;
   localparam int BKW  = 2 * PW + OW;
   localparam int MW   = NUM_BANKS * BKW + kvc_pkg::EVC_W;
   localparam int SW   = kvc_pkg::SEQ_W;
   localparam int DW   = kvc_pkg::DATA_W;
   localparam int LW   = kvc_pkg::LEN_W;
   localparam int VW   = kvc_pkg::EVC_W;

   // bank = seq_pos mod NUM_BANKS via reciprocal multiply (exact for SW-bit input)
   localparam int SH    = SW + $clog2(NUM_BANKS);
   localparam int RECIP = (2 ** SH + NUM_BANKS - 1) / NUM_BANKS;
   localparam int QPW   = SW + SH + 1;

   typedef enum logic [7:0] {
      ST_CLEAR = 8'b0000_0001,
      ST_IDLE  = 8'b0000_0010,
      ST_META  = 8'b0000_0100,
      ST_SCAN  = 8'b0000_1000,
      ST_EXEC  = 8'b0001_0000,
      ST_WRITE = 8'b0010_0000,
      ST_POP   = 8'b0100_0000,
      ST_DONE  = 8'b1000_0000
   } state_type;

   state_type state_ff, state_in;
   logic [EAW-1:0] clr_ff, clr_in;

   // latched request
   logic [kvc_pkg::FUNC_W-1:0]  func_ff, func_in;
   logic [kvc_pkg::LAYER_W-1:0] layer_ff, layer_in;
   logic [SW-1:0]               seq_ff, seq_in;
   logic [DW-1:0]               data_ff, data_in;
   logic [LW-1:0]               nbytes_ff, nbytes_in;
   logic [QPW-1:0]              qprod_ff, qprod_in;

   // working copy of the addressed layer's metadata row
   logic [NUM_BANKS-1:0][PW-1:0] wp_ff, wp_in;
   logic [NUM_BANKS-1:0][PW-1:0] rp_ff, rp_in;
   logic [NUM_BANKS-1:0][OW-1:0] occ_ff, occ_in;
   logic [VW-1:0]                evc_ff, evc_in;

   logic [BW-1:0] bank_ff, bank_in;
   logic [BW-1:0] scan_ff, scan_in;
   logic [BW-1:0] best_ff, best_in;
   logic [OW-1:0] bestocc_ff, bestocc_in;

   // pending result
   logic          zero_ff, zero_in;
   logic          res_ok_ff, res_ok_in;
   logic [DW-1:0] res_data_ff, res_data_in;
   logic [LW-1:0] res_cnt_ff, res_cnt_in;
   logic [kvc_pkg::EBANK_W-1:0] res_eb_ff, res_eb_in;

   // output register
   logic          rsp_valid_ff, rsp_valid_in;
   logic          out_ok_ff, out_ok_in;
   logic [DW-1:0] out_data_ff, out_data_in;
   logic [LW-1:0] out_cnt_ff, out_cnt_in;
   logic [kvc_pkg::EBANK_W-1:0] out_eb_ff, out_eb_in;
   logic          out_off_ff, out_off_in;
   logic [VW-1:0] out_evc_ff, out_evc_in;

   // RAM ports
   logic           ent_we;
   logic [EAW-1:0] ent_waddr, ent_raddr;
   logic [EW-1:0]  ent_wdata, ent_rdata;
   logic           meta_we;
   logic [LAW-1:0] meta_waddr, meta_raddr;
   logic [MW-1:0]  meta_wdata, meta_rdata;

   // helpers
   logic [BW-1:0]  sel;
   logic [OW-1:0]  occ_sel;
   logic [SW-1:0]  quot, rem;
   logic [EW-1:0]  mask;
   logic           offload;
   logic           out_free;

   kvc_ram #(.WIDTH(EW), .DEPTH(TOTAL_SLOTS)) u_entry_ram (
      .clock (clock),
      .we    (ent_we),
      .waddr (ent_waddr),
      .wdata (ent_wdata),
      .raddr (ent_raddr),
      .rdata (ent_rdata)
   );

   kvc_ram #(.WIDTH(MW), .DEPTH(LAYER_COUNT)) u_meta_ram (
      .clock (clock),
      .we    (meta_we),
      .waddr (meta_waddr),
      .wdata (meta_wdata),
      .raddr (meta_raddr),
      .rdata (meta_rdata)
   );

   kvc_offload #(.NUM_BANKS(NUM_BANKS), .BANK_DEPTH(BANK_DEPTH)) u_offload (
      .clock         (clock),
      .reset         (reset),
      .csr_bus       (csr_bus),
      .occ           (occ_ff),
      .needs_offload (offload)
   );

   // slot address of a bank entry: (layer*NUM_BANKS + bank)*BANK_DEPTH + ptr
   function automatic logic [EAW-1:0] slot_addr(input logic [kvc_pkg::LAYER_W-1:0] lyr,
                                                input logic [BW-1:0] bk,
                                                input logic [PW-1:0] ptr);
      slot_addr = (EAW'(lyr) * EAW'(NUM_BANKS) + EAW'(bk)) * EAW'(BANK_DEPTH) + EAW'(ptr);
   endfunction

   function automatic logic [PW-1:0] ptr_next(input logic [PW-1:0] ptr);
      ptr_next = (ptr == PW'(BANK_DEPTH - 1)) ? '0 : ptr + PW'(1);
   endfunction

   assign sel      = (state_ff == ST_SCAN) ? scan_ff : bank_ff;
   assign occ_sel  = occ_ff[sel];
   assign quot     = qprod_ff[SH +: SW];
   assign rem      = seq_ff - SW'(quot * SW'(NUM_BANKS));
   assign mask     = EW'(kvc_pkg::byte_mask(nbytes_ff));
   assign out_free = !rsp_valid_ff || rsp_bus.ready;

   assign req_bus.ready = (state_ff == ST_IDLE);

   assign rsp_bus.valid          = rsp_valid_ff;
   assign rsp_bus.ok             = out_ok_ff;
   assign rsp_bus.read_data      = out_data_ff;
   assign rsp_bus.bytes_copied   = out_cnt_ff;
   assign rsp_bus.evicted_bank   = out_eb_ff;
   assign rsp_bus.needs_offload  = out_off_ff;
   assign rsp_bus.eviction_count = out_evc_ff;

   always_comb begin
      state_in    = state_ff;
      clr_in      = clr_ff;
      func_in     = func_ff;
      layer_in    = layer_ff;
      seq_in      = seq_ff;
      data_in     = data_ff;
      nbytes_in   = nbytes_ff;
      qprod_in    = qprod_ff;
      wp_in       = wp_ff;
      rp_in       = rp_ff;
      occ_in      = occ_ff;
      evc_in      = evc_ff;
      bank_in     = bank_ff;
      scan_in     = scan_ff;
      best_in     = best_ff;
      bestocc_in  = bestocc_ff;
      zero_in     = zero_ff;
      res_ok_in   = res_ok_ff;
      res_data_in = res_data_ff;
      res_cnt_in  = res_cnt_ff;
      res_eb_in   = res_eb_ff;

      // drain the output register when the receiver takes it
      rsp_valid_in = rsp_valid_ff && !rsp_bus.ready;
      out_ok_in    = out_ok_ff;
      out_data_in  = out_data_ff;
      out_cnt_in   = out_cnt_ff;
      out_eb_in    = out_eb_ff;
      out_off_in   = out_off_ff;
      out_evc_in   = out_evc_ff;

      ent_we     = 1'b0;
      ent_waddr  = slot_addr(layer_ff, bank_ff, wp_ff[bank_ff]);
      ent_wdata  = (ent_rdata & ~mask) | (data_ff[EW-1:0] & mask);
      ent_raddr  = slot_addr(layer_ff, bank_ff, rp_ff[bank_ff]);
      meta_we    = 1'b0;
      meta_waddr = LAW'(layer_ff);
      meta_raddr = LAW'(req_bus.layer_index);
      for (int b = 0; b < NUM_BANKS; b++) begin
         meta_wdata[b*BKW +: PW]        = wp_ff[b];
         meta_wdata[b*BKW + PW +: PW]   = rp_ff[b];
         meta_wdata[b*BKW + 2*PW +: OW] = occ_ff[b];
      end
      meta_wdata[NUM_BANKS*BKW +: VW] = evc_ff;

      case (state_ff)
         ST_CLEAR: begin
            // zero one entry per cycle; metadata rows ride along on the low addresses
            ent_we     = 1'b1;
            ent_waddr  = clr_ff;
            ent_wdata  = '0;
            meta_we    = ({1'b0, clr_ff} < (EAW+1)'(LAYER_COUNT));
            meta_waddr = LAW'(clr_ff);
            meta_wdata = '0;
            if (clr_ff == EAW'(TOTAL_SLOTS - 1)) begin
               state_in = ST_IDLE;
            end else begin
               clr_in = clr_ff + EAW'(1);
            end
         end
         ST_IDLE: begin
            if (req_bus.valid) begin
               func_in   = req_bus.func;
               layer_in  = req_bus.layer_index;
               seq_in    = req_bus.seq_pos;
               data_in   = req_bus.entry_data;
               nbytes_in = (req_bus.entry_size < LW'(WORD_BYTES)) ?
                           req_bus.entry_size : LW'(WORD_BYTES);
               qprod_in  = QPW'(req_bus.seq_pos) * QPW'(RECIP);
               if (7'(req_bus.layer_index) < 7'(LAYER_COUNT)) begin
                  zero_in  = 1'b0;
                  state_in = ST_META;
               end else begin
                  // layer out of range: all-zero result, no state touched
                  zero_in  = 1'b1;
                  state_in = ST_DONE;
               end
            end
         end
         ST_META: begin
            for (int b = 0; b < NUM_BANKS; b++) begin
               wp_in[b]  = meta_rdata[b*BKW +: PW];
               rp_in[b]  = meta_rdata[b*BKW + PW +: PW];
               occ_in[b] = meta_rdata[b*BKW + 2*PW +: OW];
            end
            evc_in      = meta_rdata[NUM_BANKS*BKW +: VW];
            bank_in     = BW'(rem);
            res_ok_in   = 1'b0;
            res_data_in = '0;
            res_cnt_in  = '0;
            res_eb_in   = '0;
            if (func_ff == kvc_pkg::FUNC_EVICT) begin
               scan_in    = '0;
               best_in    = '0;
               bestocc_in = '0;
               state_in   = ST_SCAN;
            end else begin
               state_in = ST_EXEC;
            end
         end
         ST_SCAN: begin
            // strict greater-than keeps the lowest index on ties
            if (occ_sel > bestocc_ff) begin
               best_in    = scan_ff;
               bestocc_in = occ_sel;
            end
            if (scan_ff == BW'(NUM_BANKS - 1)) begin
               bank_in  = (occ_sel > bestocc_ff) ? scan_ff : best_ff;
               state_in = ST_EXEC;
            end else begin
               scan_in = scan_ff + BW'(1);
            end
         end
         ST_EXEC: begin
            state_in = ST_DONE;
            if (func_ff == kvc_pkg::FUNC_EVICT) begin
               res_eb_in = kvc_pkg::EBANK_W'(bank_ff);
            end
            case (func_ff)
               kvc_pkg::FUNC_STORE: begin
                  // read the old word so unwritten bytes keep their contents
                  if (occ_sel < OW'(BANK_DEPTH)) begin
                     ent_raddr = slot_addr(layer_ff, bank_ff, wp_ff[bank_ff]);
                     state_in  = ST_WRITE;
                  end
               end
               kvc_pkg::FUNC_LOAD,
               kvc_pkg::FUNC_EVICT: begin
                  if (occ_sel != '0) begin
                     ent_raddr       = slot_addr(layer_ff, bank_ff, rp_ff[bank_ff]);
                     rp_in[bank_ff]  = ptr_next(rp_ff[bank_ff]);
                     occ_in[bank_ff] = occ_sel - OW'(1);
                     if (func_ff == kvc_pkg::FUNC_EVICT) begin
                        evc_in = evc_ff + VW'(1);
                     end
                     state_in = ST_POP;
                  end
               end
               kvc_pkg::FUNC_QUERY: begin
                  res_ok_in = 1'b1;
               end
               default: begin
                  res_ok_in = 1'b0;
               end
            endcase
         end
         ST_WRITE: begin
            // merge and write back, advance the write pointer
            ent_we          = 1'b1;
            wp_in[bank_ff]  = ptr_next(wp_ff[bank_ff]);
            occ_in[bank_ff] = occ_sel + OW'(1);
            res_ok_in       = 1'b1;
            res_cnt_in      = nbytes_ff;
            state_in        = ST_DONE;
         end
         ST_POP: begin
            res_data_in = DW'(ent_rdata & mask);
            res_ok_in   = 1'b1;
            res_cnt_in  = nbytes_ff;
            state_in    = ST_DONE;
         end
         ST_DONE: begin
            // hold until the output register is free, then write the row back
            if (out_free) begin
               rsp_valid_in = 1'b1;
               out_ok_in    = res_ok_ff && !zero_ff;
               out_data_in  = zero_ff ? '0 : res_data_ff;
               out_cnt_in   = zero_ff ? '0 : res_cnt_ff;
               out_eb_in    = zero_ff ? '0 : res_eb_ff;
               out_off_in   = offload && !zero_ff;
               out_evc_in   = zero_ff ? '0 : evc_ff;
               meta_we      = !zero_ff;
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_CLEAR;
         clr_ff       <= '0;
         rsp_valid_ff <= 1'b0;
         zero_ff      <= 1'b0;
      end else begin
         state_ff     <= state_in;
         clr_ff       <= clr_in;
         rsp_valid_ff <= rsp_valid_in;
         zero_ff      <= zero_in;
      end
   end

   always_ff @(posedge clock) begin
      func_ff     <= func_in;
      layer_ff    <= layer_in;
      seq_ff      <= seq_in;
      data_ff     <= data_in;
      nbytes_ff   <= nbytes_in;
      qprod_ff    <= qprod_in;
      wp_ff       <= wp_in;
      rp_ff       <= rp_in;
      occ_ff      <= occ_in;
      evc_ff      <= evc_in;
      bank_ff     <= bank_in;
      scan_ff     <= scan_in;
      best_ff     <= best_in;
      bestocc_ff  <= bestocc_in;
      res_ok_ff   <= res_ok_in;
      res_data_ff <= res_data_in;
      res_cnt_ff  <= res_cnt_in;
      res_eb_ff   <= res_eb_in;
      out_ok_ff   <= out_ok_in;
      out_data_ff <= out_data_in;
      out_cnt_ff  <= out_cnt_in;
      out_eb_ff   <= out_eb_in;
      out_off_ff  <= out_off_in;
      out_evc_ff  <= out_evc_in;
   end

endmodule

[src/kvc_ram.sv]
// ---------------------------------------------------------------------------
// kvc_ram: generic single-write, single-read RAM
// One write port, one read port, read data registered.
// ---------------------------------------------------------------------------
module kvc_ram #(
   parameter int WIDTH = 64,
   parameter int DEPTH = 256
) (
   input  logic                              clock,
   input  logic                              we,
   input  logic [$clog2(DEPTH > 1 ? DEPTH : 2)-1:0] waddr,
   input  logic [WIDTH-1:0]                  wdata,
   input  logic [$clog2(DEPTH > 1 ? DEPTH : 2)-1:0] raddr,
   output logic [WIDTH-1:0]                  rdata
);

   logic [WIDTH-1:0] mem [DEPTH];

   always_ff @(posedge clock) begin
      if (we) begin
         mem[waddr] <= wdata;
      end
      rdata <= mem[raddr];
   end

endmodule

[src/kvc_offload.sv]
// ---------------------------------------------------------------------------
// kvc_offload: offload threshold register and occupancy compare
// Holds depth*percent; flags when any bank reaches depth*percent/100.
// ---------------------------------------------------------------------------
module kvc_offload #(
   parameter int NUM_BANKS  = kvc_pkg::NUM_BANKS_DEF,
   parameter int BANK_DEPTH = kvc_pkg::BANK_DEPTH_DEF
) (
   input  logic                 clock,
   input  logic                 reset,
   kvc_csr_if.sink              csr_bus,
   input  logic [NUM_BANKS-1:0][kvc_pkg::occ_width(BANK_DEPTH)-1:0] occ,
   output logic                 needs_offload
);

   localparam int OW   = kvc_pkg::occ_width(BANK_DEPTH);
   localparam int TPW  = $clog2(BANK_DEPTH * 127 + 1);
   localparam int CMPW = $clog2(128 * (BANK_DEPTH + 1));

   logic [TPW-1:0] tprod_ff, tprod_in;

   assign csr_bus.ready = 1'b1;

   // keep depth*percent; occ >= floor(p/100) holds exactly when 100*(occ+1) > p
   always_comb begin
      tprod_in = tprod_ff;
      if (csr_bus.valid) begin
         tprod_in = TPW'(csr_bus.offload_percent) * TPW'(BANK_DEPTH);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         tprod_ff <= TPW'(BANK_DEPTH * kvc_pkg::PCT_RESET);
      end else begin
         tprod_ff <= tprod_in;
      end
   end

   always_comb begin
      needs_offload = 1'b0;
      for (int b = 0; b < NUM_BANKS; b++) begin
         if (CMPW'({1'b0, occ[b]} + (OW+1)'(1)) * CMPW'(kvc_pkg::PCT_SCALE)
             > CMPW'(tprod_ff)) begin
            needs_offload = 1'b1;
         end
      end
   end

endmodule

[bench/banked_kv_fifo_cache_test.sv]
`timescale 1ns / 100ps
// ---------------------------------------------------------------------------
// banked_kv_fifo_cache_test: self-checking bench of the banked KV FIFO cache
// Drives store, load, evict and query transactions under random idling on
// both channels, mirrors every bank in a behavioral copy of the cache and
// checks each response field against it, over several offload percentages.
// ---------------------------------------------------------------------------
module banked_kv_fifo_cache_test;

   localparam int NL    = kvc_pkg::LAYER_COUNT_DEF;
   localparam int NB    = kvc_pkg::NUM_BANKS_DEF;
   localparam int DEPTH = kvc_pkg::BANK_DEPTH_DEF;
   localparam int EB    = kvc_pkg::WORD_BYTES_DEF;
   localparam int RANDOM_PHASES   = 4;
   localparam int ITEMS_PER_PHASE = 100;

   // one request transaction
   typedef struct packed {
      kvc_pkg::func_type                 func;
      logic [kvc_pkg::LAYER_W-1:0]       layer;
      logic [kvc_pkg::SEQ_W-1:0]         seq;
      logic [kvc_pkg::DATA_W-1:0]        data;
      logic [kvc_pkg::LEN_W-1:0]         len;
   } cache_op_type;

   // one response transaction
   typedef struct packed {
      logic                              ok;
      logic [kvc_pkg::DATA_W-1:0]        read_data;
      logic [kvc_pkg::LEN_W-1:0]         bytes_copied;
      logic [kvc_pkg::EBANK_W-1:0]       evicted_bank;
      logic                              needs_offload;
      logic [kvc_pkg::EVC_W-1:0]         eviction_count;
   } cache_result_type;

   // request plus an optional hand-written answer
   typedef struct packed {
      cache_op_type         op;
      logic                 typed;
      cache_result_type     want;
   } cache_row_type;

   typedef enum int {BURST_FILL, BURST_DRAIN, BURST_MIXED} burst_kind_type;

   logic clock;
   logic reset;

   kvc_req_if req_bus ();
   kvc_rsp_if rsp_bus ();
   kvc_csr_if csr_bus ();

   banked_kv_fifo_cache i_dut (
      .clock   (clock),
      .reset   (reset),
      .req_bus (req_bus),
      .rsp_bus (rsp_bus),
      .csr_bus (csr_bus)
   );

   // -------------------------------------------------------------------------
   // Shadow copy of the cache contents and bank bookkeeping
   // -------------------------------------------------------------------------
   logic [kvc_pkg::DATA_W-1:0] slot_word [NL*NB][DEPTH];
   int                         wr_ptr    [NL*NB];
   int                         rd_ptr    [NL*NB];
   int                         occupancy [NL*NB];
   logic [kvc_pkg::EVC_W-1:0]  evictions [NL];
   int                         shadow_percent = kvc_pkg::PCT_RESET;

   cache_result_type  pending_results [$];   // responses still owed by the DUT
   cache_row_type     issued_rows     [$];   // requests driven, not yet accepted
   int                mismatch_count = 0;
   int                result_index   = 0;
   int                snd_idle_pct   = 0;
   int                rcv_idle_pct   = 0;

   initial begin
      for (int b = 0; b < NL*NB; b++) begin
         wr_ptr[b]    = 0;
         rd_ptr[b]    = 0;
         occupancy[b] = 0;
         for (int s = 0; s < DEPTH; s++) begin
            slot_word[b][s] = '0;
         end
      end
      for (int l = 0; l < NL; l++) begin
         evictions[l] = '0;
      end
   end

   // Apply one operation to the shadow cache and return the response it owes.
   function automatic cache_result_type predict_cache_result(input cache_op_type op);
      cache_result_type           r;
      logic [kvc_pkg::DATA_W-1:0] m;
      int                         n;
      int                         bank;
      int                         pop_bank;
      int                         best;
      int                         thresh;
      r        = '0;
      pop_bank = -1;
      n        = (op.len > EB) ? EB : int'(op.len);
      m        = (n >= 8) ? '1 : ((64'd1 << (8 * n)) - 64'd1);
      bank     = int'(op.layer) * NB + int'(op.seq) % NB;
      case (op.func)
         kvc_pkg::FUNC_STORE: begin
            // refuse on a full bank; partial writes keep the old upper bytes
            if (occupancy[bank] < DEPTH) begin
               slot_word[bank][wr_ptr[bank]] =
                  (slot_word[bank][wr_ptr[bank]] & ~m) | (op.data & m);
               wr_ptr[bank]    = (wr_ptr[bank] + 1) % DEPTH;
               occupancy[bank] = occupancy[bank] + 1;
               r.ok            = 1'b1;
               r.bytes_copied  = kvc_pkg::LEN_W'(n);
            end
         end
         kvc_pkg::FUNC_LOAD: begin
            pop_bank = bank;
         end
         kvc_pkg::FUNC_EVICT: begin
            // fullest bank of the layer, lowest index on ties
            best = 0;
            for (int b = 1; b < NB; b++) begin
               if (occupancy[int'(op.layer)*NB + b] > occupancy[int'(op.layer)*NB + best]) begin
                  best = b;
               end
            end
            r.evicted_bank = kvc_pkg::EBANK_W'(best);
            pop_bank       = int'(op.layer) * NB + best;
         end
         default: begin
            r.ok = 1'b1;
         end
      endcase
      if (pop_bank >= 0 && occupancy[pop_bank] != 0) begin
         r.read_data         = slot_word[pop_bank][rd_ptr[pop_bank]] & m;
         rd_ptr[pop_bank]    = (rd_ptr[pop_bank] + 1) % DEPTH;
         occupancy[pop_bank] = occupancy[pop_bank] - 1;
         r.ok                = 1'b1;
         r.bytes_copied      = kvc_pkg::LEN_W'(n);
         if (op.func == kvc_pkg::FUNC_EVICT) begin
            evictions[op.layer] = evictions[op.layer] + 1;
         end
      end
      thresh = (DEPTH * shadow_percent) / kvc_pkg::PCT_SCALE;
      for (int b = 0; b < NB; b++) begin
         if (occupancy[int'(op.layer)*NB + b] >= thresh) begin
            r.needs_offload = 1'b1;
         end
      end
      r.eviction_count = evictions[op.layer];
      return r;
   endfunction

   // Build one random request, steered by the current burst.
   function automatic cache_op_type random_cache_op(input burst_kind_type kind,
                                                    input int layer_focus,
                                                    input int bank_focus);
      cache_op_type op;
      int           roll;
      int           store_cut;
      int           load_cut;
      int           evict_cut;
      case (kind)
         BURST_FILL:  begin store_cut = 70; load_cut = 80; evict_cut = 90; end
         BURST_DRAIN: begin store_cut = 15; load_cut = 60; evict_cut = 90; end
         default:     begin store_cut = 25; load_cut = 50; evict_cut = 75; end
      endcase
      roll = $urandom_range(0, 99);
      if (roll < store_cut) begin
         op.func = kvc_pkg::FUNC_STORE;
      end else if (roll < load_cut) begin
         op.func = kvc_pkg::FUNC_LOAD;
      end else if (roll < evict_cut) begin
         op.func = kvc_pkg::FUNC_EVICT;
      end else begin
         op.func = kvc_pkg::FUNC_QUERY;
      end
      op.layer = ($urandom_range(0, 99) < 80) ? kvc_pkg::LAYER_W'(layer_focus)
                                              : kvc_pkg::LAYER_W'($urandom);
      op.seq   = kvc_pkg::SEQ_W'($urandom);
      if ($urandom_range(0, 99) < 75) begin
         // keep the upper position bits random, pin the bank
         op.seq = (op.seq & ~kvc_pkg::SEQ_W'(NB - 1)) | kvc_pkg::SEQ_W'(bank_focus);
      end
      op.data = {$urandom, $urandom};
      op.len  = ($urandom_range(0, 1) == 0) ? kvc_pkg::LEN_W'(EB)
                                            : kvc_pkg::LEN_W'($urandom_range(0, 15));
      return op;
   endfunction

   task automatic flag_mismatch(input string msg);
      mismatch_count++;
      $display("[%0t] response %0d: %s", $realtime, result_index, msg);
   endtask

   // -------------------------------------------------------------------------
   // Clock and response-side backpressure
   // -------------------------------------------------------------------------
   initial begin
      clock = 1'b0;
      forever #1 clock = ~clock;
   end

   initial begin
      rsp_bus.ready <= 1'b0;
      forever begin
         @(posedge clock);
         // stall the response channel at the rate set for the current phase
         rsp_bus.ready <= ($urandom_range(0, 99) >= rcv_idle_pct);
      end
   end

   // -------------------------------------------------------------------------
   // Monitor: predict on every accepted request, check every accepted response
   // -------------------------------------------------------------------------
   always @(posedge clock) begin
      cache_op_type     op;
      cache_row_type    row;
      cache_result_type got;
      cache_result_type want;
      if (!reset) begin
         if (csr_bus.valid && csr_bus.ready) begin
            shadow_percent = int'(csr_bus.offload_percent);
         end
         if (req_bus.valid && req_bus.ready) begin
            op.func  = kvc_pkg::func_type'(req_bus.func);
            op.layer = req_bus.layer_index;
            op.seq   = req_bus.seq_pos;
            op.data  = req_bus.entry_data;
            op.len   = req_bus.entry_size;
            want     = predict_cache_result(op);
            if (issued_rows.size() != 0) begin
               row = issued_rows.pop_front();
               // a hand-written answer takes the place of the prediction
               if (row.typed) begin
                  want = row.want;
               end
            end
            pending_results.push_back(want);
         end
         if (rsp_bus.valid && rsp_bus.ready) begin
            got = '{rsp_bus.ok, rsp_bus.read_data, rsp_bus.bytes_copied,
                    rsp_bus.evicted_bank, rsp_bus.needs_offload, rsp_bus.eviction_count};
            if (pending_results.size() == 0) begin
               flag_mismatch("response with no request outstanding");
            end else begin
               want = pending_results.pop_front();
               if (got.ok !== want.ok) begin
                  flag_mismatch($sformatf("ok %0b, expected %0b", got.ok, want.ok));
               end
               if (got.read_data !== want.read_data) begin
                  flag_mismatch($sformatf("read_data %h, expected %h",
                                          got.read_data, want.read_data));
               end
               if (got.bytes_copied !== want.bytes_copied) begin
                  flag_mismatch($sformatf("bytes_copied %0d, expected %0d",
                                          got.bytes_copied, want.bytes_copied));
               end
               if (got.evicted_bank !== want.evicted_bank) begin
                  flag_mismatch($sformatf("evicted_bank %0d, expected %0d",
                                          got.evicted_bank, want.evicted_bank));
               end
               if (got.needs_offload !== want.needs_offload) begin
                  flag_mismatch($sformatf("needs_offload %0b, expected %0b",
                                          got.needs_offload, want.needs_offload));
               end
               if (got.eviction_count !== want.eviction_count) begin
                  flag_mismatch($sformatf("eviction_count %0d, expected %0d",
                                          got.eviction_count, want.eviction_count));
               end
            end
            result_index++;
         end
      end
   end

   // -------------------------------------------------------------------------
   // Request driver
   // -------------------------------------------------------------------------

   // Present one request transaction and hold it until the DUT takes it.
   task automatic send_item(input cache_row_type row);
      // insert random idle cycles ahead of the transaction
      while ($urandom_range(0, 99) < snd_idle_pct) begin
         req_bus.valid <= 1'b0;
         @(posedge clock);
      end
      req_bus.valid       <= 1'b1;
      req_bus.func        <= row.op.func;
      req_bus.layer_index <= row.op.layer;
      req_bus.seq_pos     <= row.op.seq;
      req_bus.entry_data  <= row.op.data;
      req_bus.entry_size  <= row.op.len;
      issued_rows.push_back(row);
      do begin
         @(posedge clock);
      end while (!req_bus.ready);
   endtask

   // Drop valid and hold until every owed response has come back.
   task automatic wait_for_idle();
      req_bus.valid <= 1'b0;
      @(posedge clock);
      while (pending_results.size() != 0) begin
         @(posedge clock);
      end
      // let the sequencer settle back to idle before touching the register
      repeat (16) @(posedge clock);
   endtask

   // Write the offload percentage; call only while the cache is idle.
   task automatic write_offload_percent(input int pct);
      csr_bus.valid           <= 1'b1;
      csr_bus.offload_percent <= kvc_pkg::PCT_W'(pct);
      do begin
         @(posedge clock);
      end while (!csr_bus.ready);
      csr_bus.valid <= 1'b0;
   endtask

   // -------------------------------------------------------------------------
   // Directed stimulus, at the reset percentage (threshold 12 of 16)
   //   columns: {func, layer, seq, data, len}, typed, {ok, read_data,
   //   bytes_copied, evicted_bank, needs_offload, eviction_count}
   // -------------------------------------------------------------------------
   localparam int DIRECTED_ROWS = 23;
   cache_row_type directed_rows [DIRECTED_ROWS] = '{
      // query and refused pops on a freshly cleared cache
      '{'{kvc_pkg::FUNC_QUERY, 2'd0, 12'd0,    64'd0, 4'd0}, 1'b1,
        '{1'b1, 64'd0, 4'd0, 2'd0, 1'b0, 32'd0}},
      '{'{kvc_pkg::FUNC_LOAD,  2'd0, 12'd0,    64'd0, 4'd8}, 1'b1,
        '{1'b0, 64'd0, 4'd0, 2'd0, 1'b0, 32'd0}},
      '{'{kvc_pkg::FUNC_EVICT, 2'd3, 12'd4095, 64'hFFFF_FFFF_FFFF_FFFF, 4'd8}, 1'b1,
        '{1'b0, 64'd0, 4'd0, 2'd0, 1'b0, 32'd0}},
      // full-width store, partial store, saturated length, zero length
      '{'{kvc_pkg::FUNC_STORE, 2'd0, 12'd0,    64'hFFFF_FFFF_FFFF_FFFF, 4'd8}, 1'b1,
        '{1'b1, 64'd0, 4'd8, 2'd0, 1'b0, 32'd0}},
      '{'{kvc_pkg::FUNC_STORE, 2'd0, 12'd4,    64'h0123_4567_89AB_CDEF, 4'd3}, 1'b0, '0},
      '{'{kvc_pkg::FUNC_STORE, 2'd0, 12'd4095, 64'hDEAD_BEEF_0BAD_F00D, 4'd15}, 1'b1,
        '{1'b1, 64'd0, 4'd8, 2'd0, 1'b0, 32'd0}},
      '{'{kvc_pkg::FUNC_STORE, 2'd0, 12'd1,    64'hFFFF_FFFF_FFFF_FFFF, 4'd0}, 1'b0, '0},
      // pops in FIFO order, short and oversized lengths
      '{'{kvc_pkg::FUNC_LOAD,  2'd0, 12'd0,    64'd0, 4'd8},  1'b0, '0},
      '{'{kvc_pkg::FUNC_LOAD,  2'd0, 12'd8,    64'd0, 4'd2},  1'b0, '0},
      '{'{kvc_pkg::FUNC_LOAD,  2'd0, 12'd1,    64'd0, 4'd15}, 1'b0, '0},
      // evict finds the only occupied bank, then the layer runs dry
      '{'{kvc_pkg::FUNC_EVICT, 2'd0, 12'd0,    64'd0, 4'd15}, 1'b0, '0},
      '{'{kvc_pkg::FUNC_EVICT, 2'd0, 12'd0,    64'd0, 4'd8},  1'b0, '0},
      // equal occupancy in two banks: the lower index goes first
      '{'{kvc_pkg::FUNC_STORE, 2'd1, 12'd5,    64'h8000_0000_0000_0001, 4'd8}, 1'b0, '0},
      '{'{kvc_pkg::FUNC_STORE, 2'd1, 12'd2,    64'h7FFF_FFFF_FFFF_FFFE, 4'd8}, 1'b0, '0},
      '{'{kvc_pkg::FUNC_EVICT, 2'd1, 12'd3,    64'd0, 4'd8}, 1'b0, '0},
      '{'{kvc_pkg::FUNC_EVICT, 2'd1, 12'd3,    64'd0, 4'd4}, 1'b0, '0},
      // zero-length load still pops, the bank is then empty
      '{'{kvc_pkg::FUNC_STORE, 2'd2, 12'd3,    64'h5555_5555_5555_5555, 4'd8}, 1'b0, '0},
      '{'{kvc_pkg::FUNC_LOAD,  2'd2, 12'd7,    64'd0, 4'd0}, 1'b0, '0},
      '{'{kvc_pkg::FUNC_LOAD,  2'd2, 12'd3,    64'd0, 4'd8}, 1'b0, '0},
      // query ignores its payload
      '{'{kvc_pkg::FUNC_STORE, 2'd3, 12'd4092, 64'd0, 4'd8}, 1'b0, '0},
      '{'{kvc_pkg::FUNC_QUERY, 2'd3, 12'd4095, 64'hFFFF_FFFF_FFFF_FFFF, 4'd15}, 1'b0, '0},
      '{'{kvc_pkg::FUNC_LOAD,  2'd3, 12'd0,    64'hAAAA_AAAA_AAAA_AAAA, 4'd8}, 1'b0, '0},
      '{'{kvc_pkg::FUNC_STORE, 2'd0, 12'd0,    64'hAAAA_AAAA_AAAA_AAAA, 4'd4}, 1'b0, '0}
   };

   // offload percentage of each random phase: always, never, only when full,
   // and a mid value
   int phase_percent [RANDOM_PHASES] = '{0, 127, 100, 45};

   // -------------------------------------------------------------------------
   // Main sequence
   // -------------------------------------------------------------------------
   initial begin
      cache_row_type  row;
      burst_kind_type kind;
      int             burst_left;
      int             layer_focus;
      int             bank_focus;

      reset                   <= 1'b1;
      req_bus.valid           <= 1'b0;
      req_bus.func            <= kvc_pkg::FUNC_STORE;
      req_bus.layer_index     <= '0;
      req_bus.seq_pos         <= '0;
      req_bus.entry_data      <= '0;
      req_bus.entry_size      <= '0;
      csr_bus.valid           <= 1'b0;
      csr_bus.offload_percent <= '0;
      repeat (2) @(posedge clock);
      reset <= 1'b0;

      // directed rows: sender idles lightly, receiver heavily
      snd_idle_pct = 8;
      rcv_idle_pct = 48;
      foreach (directed_rows[i]) begin
         send_item(directed_rows[i]);
      end
      wait_for_idle();

      for (int p = 0; p < RANDOM_PHASES; p++) begin
         write_offload_percent(phase_percent[p]);
         // swap the idling sides after the first phase, then run at full rate
         case (p)
            0:       begin snd_idle_pct = 8;  rcv_idle_pct = 48; end
            1:       begin snd_idle_pct = 48; rcv_idle_pct = 8;  end
            default: begin snd_idle_pct = 0;  rcv_idle_pct = 0;  end
         endcase
         burst_left = 0;
         for (int i = 0; i < ITEMS_PER_PHASE; i++) begin
            if (burst_left == 0) begin
               // pick a new burst: fill a bank, drain it, or mix
               kind        = burst_kind_type'($urandom_range(0, 2));
               layer_focus = $urandom_range(0, NL - 1);
               bank_focus  = $urandom_range(0, NB - 1);
               burst_left  = $urandom_range(8, 24);
            end
            burst_left--;
            if (i == ITEMS_PER_PHASE / 2) begin
               // hold the sender until every response has drained
               wait_for_idle();
            end
            row.op    = random_cache_op(kind, layer_focus, bank_focus);
            row.typed = 1'b0;
            row.want  = '0;
            send_item(row);
         end
         wait_for_idle();
      end

      if (mismatch_count == 0) begin
         $display("banked_kv_fifo_cache verification clean");
      end else begin
         $display("banked_kv_fifo_cache verification failed");
      end
      $finish;
   end

   // Abort a hung run: far beyond the slowest legal run of ~430 transactions.
   initial begin
      #400_000;
      $display("banked_kv_fifo_cache verification failed");
      $finish;
   end

endmodule
